/* rtl/core/pfde_pkg.sv */
// Package: types, constants and glyph font for the page framebuffer draw engine.
package pfde_pkg;

   localparam int FB_WIDTH_DEF  = 128;
   localparam int FB_HEIGHT_DEF = 64;
   localparam int GLYPH_W       = 6;
   localparam int GLYPH_H       = 8;
   localparam logic [7:0] CODE_FIRST = 8'h20;
   localparam logic [7:0] CODE_LAST  = 8'h5A;

   typedef enum logic [3:0] {
      MODE_CLEAR_ALL = 4'd0,
      MODE_SET_PX    = 4'd1,
      MODE_CLR_PX    = 4'd2,
      MODE_HLINE     = 4'd3,
      MODE_VLINE     = 4'd4,
      MODE_RECT      = 4'd5,
      MODE_FILL      = 4'd6,
      MODE_CLR_RECT  = 4'd7,
      MODE_RING      = 4'd8,
      MODE_DISC      = 4'd9,
      MODE_CHAR      = 4'd10,
      MODE_READ      = 4'd11
   } mode_type;

   typedef struct packed {
      logic [3:0] mode;
      logic [7:0] x_start;
      logic [7:0] y_start;
      logic [7:0] x_end;
      logic [7:0] y_end;
      logic [7:0] radius;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic       read_valid;
   } rsp_type;

   // one font column, bit n is glyph row n
   function automatic logic [7:0] glyph_col(input logic [7:0] code, input logic [2:0] col);
      logic [47:0] g;
      logic [7:0]  c;
      begin
         c = (code < CODE_FIRST || code > CODE_LAST) ? CODE_FIRST : code;
         unique case (c)
            8'h21: g = 48'h00005F000000;
            8'h22: g = 48'h000700070000;
            8'h23: g = 48'h147F147F1400;
            8'h24: g = 48'h242A7F2A1200;
            8'h25: g = 48'h231308646200;
            8'h26: g = 48'h364956205000;
            8'h27: g = 48'h000807030000;
            8'h28: g = 48'h001C22410000;
            8'h29: g = 48'h0041221C0000;
            8'h2A: g = 48'h2A1C7F1C2A00;
            8'h2B: g = 48'h08083E080800;
            8'h2C: g = 48'h008070300000;
            8'h2D: g = 48'h080808080800;
            8'h2E: g = 48'h000060600000;
            8'h2F: g = 48'h201008040200;
            8'h30: g = 48'h3E5149453E00;
            8'h31: g = 48'h00427F400000;
            8'h32: g = 48'h724949494600;
            8'h33: g = 48'h2141494D3300;
            8'h34: g = 48'h1814127F1000;
            8'h35: g = 48'h274545453900;
            8'h36: g = 48'h3C4A49493100;
            8'h37: g = 48'h412111090700;
            8'h38: g = 48'h364949493600;
            8'h39: g = 48'h464949291E00;
            8'h3A: g = 48'h003636000000;
            8'h3B: g = 48'h005636000000;
            8'h3C: g = 48'h081422410000;
            8'h3D: g = 48'h141414141400;
            8'h3E: g = 48'h004122140800;
            8'h3F: g = 48'h020159090600;
            8'h40: g = 48'h3E415D594E00;
            8'h41: g = 48'h7C1211127C00;
            8'h42: g = 48'h7F4949493600;
            8'h43: g = 48'h3E4141412200;
            8'h44: g = 48'h7F4141413E00;
            8'h45: g = 48'h7F4949494100;
            8'h46: g = 48'h7F0909090100;
            8'h47: g = 48'h3E4141517300;
            8'h48: g = 48'h7F0808087F00;
            8'h49: g = 48'h00417F410000;
            8'h4A: g = 48'h2040413F0100;
            8'h4B: g = 48'h7F0814224100;
            8'h4C: g = 48'h7F4040404000;
            8'h4D: g = 48'h7F020C027F00;
            8'h4E: g = 48'h7F0408107F00;
            8'h4F: g = 48'h3E4141413E00;
            8'h50: g = 48'h7F0909090600;
            8'h51: g = 48'h3E4151215E00;
            8'h52: g = 48'h7F0919294600;
            8'h53: g = 48'h264949493200;
            8'h54: g = 48'h03017F010300;
            8'h55: g = 48'h3F4040403F00;
            8'h56: g = 48'h1F2040201F00;
            8'h57: g = 48'h3F4038403F00;
            8'h58: g = 48'h631408146300;
            8'h59: g = 48'h030478040300;
            8'h5A: g = 48'h6159494D4300;
            default: g = 48'h0;
         endcase
         unique case (col)
            3'd0: glyph_col = g[47:40];
            3'd1: glyph_col = g[39:32];
            3'd2: glyph_col = g[31:24];
            3'd3: glyph_col = g[23:16];
            3'd4: glyph_col = g[15:8];
            default: glyph_col = g[7:0];
         endcase
      end
   endfunction

endpackage

/* rtl/core/pfde_ram.sv */
// Generic single-port RAM with registered read.
module pfde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

/* rtl/core/page_framebuffer_draw_engine_unit.sv */
// Top level: page framebuffer drawing engine with pixel sequencer and frame store.
//
// A command is taken when start is high and busy is low. The block then stays
// busy while it walks the shape, and it answers with exactly one result. The
// result is shown for one cycle with rsp_done high, and the receiver cannot
// stall it. Every pixel is a read-modify-write of one frame byte through the
// single RAM port: select, read, data and write. The pixels visited are:
//  - for a pixel, line or box, each of its clipped pixels;
//  - for a rectangle outline, each pixel of each side after one setup step
//    per side, and a side that is clipped away is skipped;
//  - for a circle, every pixel of its clipped bounding box, and each pixel
//    takes two more steps for the squares of its x and y offsets;
//  - for a glyph, its 6x8 cells.
// A read and an unused mode visit no pixel. Clear all sweeps one byte a cycle.
// After reset the block sweeps the frame store to zero, one byte a cycle,
// with busy high. The circle test runs through one shared 9-bit multiplier,
// one product a cycle. It squares the radius at segment setup and then the
// offsets of each pixel.
module page_framebuffer_draw_engine_unit
   import pfde_pkg::*;
#(
   parameter int FB_WIDTH  = FB_WIDTH_DEF,
   parameter int FB_HEIGHT = FB_HEIGHT_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_done,
   output rsp_type rsp_item
);
   localparam int PAGES = (FB_HEIGHT + 7) / 8;
   localparam int BYTES = FB_WIDTH * PAGES;
   localparam int AW    = $clog2(BYTES);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_SEG, S_PIX, S_MUL1, S_MUL2, S_RD, S_WAIT, S_WR, S_RRD,
      S_RWAIT, S_DONE
   } state_type;

   state_type  state_ff;
   req_type    req_ff;
   logic [AW:0] cnt_ff;
   logic [8:0] x_ff, y_ff, xa_ff, xb_ff, ya_ff, yb_ff;
   logic [1:0] seg_ff;
   logic [17:0] d2_ff;
   logic [17:0] r2_ff;
   logic [17:0] prod;
   logic [8:0]  mul_a;
   logic       hit_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_valid_ff;
   logic       done_ff;

   logic            ram_we;
   logic [AW-1:0]   ram_addr;
   logic [7:0]      ram_wd, ram_rd;

   // shared multiplier: radius or offset magnitude squared
   assign prod = mul_a * mul_a;

   // pixel offset from circle center, magnitude
   logic signed [9:0] dxs, dys;
   logic [8:0]  rad9;
   assign rad9 = {1'b0, req_ff.radius};
   assign dxs = $signed({1'b0, x_ff}) - $signed({2'b0, req_ff.x_start});
   assign dys = $signed({1'b0, y_ff}) - $signed({2'b0, req_ff.y_start});
   always_comb begin
      if (state_ff == S_SEG) begin
         mul_a = rad9;
      end else if (state_ff == S_MUL1) begin
         mul_a = dxs[9] ? 9'(-dxs) : dxs[8:0];
      end else begin
         mul_a = dys[9] ? 9'(-dys) : dys[8:0];
      end
   end

   logic [17:0] rlo, rhi;
   // ring band r(r-1)+1 .. r(r+1), from r^2 latched at setup
   assign rlo = r2_ff - 18'(rad9) + 18'd1;
   assign rhi = r2_ff + 18'(rad9);

   // address of current pixel
   logic [AW-1:0] pix_addr;
   logic [7:0]    pix_mask;
   assign pix_addr = AW'((y_ff >> 3) * FB_WIDTH + (FB_WIDTH - 1 - x_ff));
   assign pix_mask = 8'(1) << y_ff[2:0];

   logic inb;
   assign inb = (x_ff < 9'(FB_WIDTH)) && (y_ff < 9'(FB_HEIGHT));

   logic pix_on;
   logic [7:0] gcol;
   assign gcol = glyph_col(req_ff.char_code, 3'(x_ff - {1'b0, req_ff.x_start}));
   always_comb begin
      unique case (mode_type'(req_ff.mode))
         MODE_CLR_PX, MODE_CLR_RECT: pix_on = 1'b0;
         MODE_CHAR: pix_on = gcol[3'(y_ff - {1'b0, req_ff.y_start})];
         default: pix_on = 1'b1;
      endcase
   end

   // segment bounds (ordered, far corner clipped)
   logic [7:0] sx0, sx1, sy0, sy1;
   always_comb begin
      sx0 = req_ff.x_start; sx1 = req_ff.x_end;
      sy0 = req_ff.y_start; sy1 = req_ff.y_end;
      unique case (mode_type'(req_ff.mode))
         MODE_HLINE: sy1 = req_ff.y_start;
         MODE_VLINE: sx1 = req_ff.x_start;
         MODE_RECT: begin
            unique case (seg_ff)
               2'd0: sy1 = req_ff.y_start;
               2'd1: begin sy0 = req_ff.y_end; end
               2'd2: sx1 = req_ff.x_start;
               default: sx0 = req_ff.x_end;
            endcase
         end
         default: ;
      endcase
   end

   logic [8:0] bx0, bx1, by0, by1;
   always_comb begin
      bx0 = {1'b0, (sx0 > sx1) ? sx1 : sx0};
      bx1 = {1'b0, (sx0 > sx1) ? sx0 : sx1};
      by0 = {1'b0, (sy0 > sy1) ? sy1 : sy0};
      by1 = {1'b0, (sy0 > sy1) ? sy0 : sy1};
      if (bx1 > 9'(FB_WIDTH - 1))  bx1 = 9'(FB_WIDTH - 1);
      if (by1 > 9'(FB_HEIGHT - 1)) by1 = 9'(FB_HEIGHT - 1);
   end

   logic is_circ;
   assign is_circ = (req_ff.mode == MODE_RING) || (req_ff.mode == MODE_DISC);

   logic last_seg;
   assign last_seg = (req_ff.mode != MODE_RECT) || (seg_ff == 2'd3);

   always_comb begin
      ram_we   = 1'b0;
      ram_wd   = '0;
      ram_addr = pix_addr;
      unique case (state_ff)
         S_INIT: begin
            ram_we = 1'b1; ram_addr = cnt_ff[AW-1:0];
         end
         S_WR: begin
            ram_we = hit_ff;
            ram_wd = pix_on ? (ram_rd | pix_mask) : (ram_rd & ~pix_mask);
         end
         S_RRD, S_RWAIT: ram_addr = AW'(req_ff.y_start * FB_WIDTH + req_ff.x_start);
         default: ;
      endcase
   end

   pfde_ram #(.WIDTH(8), .DEPTH(BYTES)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr), .wr_data(ram_wd),
      .rd_data(ram_rd)
   );

   // walk to next pixel, returns done flag
   logic [8:0] nx, ny;
   logic       walk_end;
   always_comb begin
      nx = x_ff + 9'd1; ny = y_ff; walk_end = 1'b0;
      if (x_ff >= xb_ff) begin
         nx = xa_ff; ny = y_ff + 9'd1;
         walk_end = (y_ff >= yb_ff);
      end
   end

   logic [8:0] cxa, cxb, cya, cyb;
   always_comb begin
      cxa = (req_ff.x_start < req_ff.radius) ? 9'd0 : 9'(req_ff.x_start - req_ff.radius);
      cya = (req_ff.y_start < req_ff.radius) ? 9'd0 : 9'(req_ff.y_start - req_ff.radius);
      cxb = 9'(req_ff.x_start) + 9'(req_ff.radius);
      cyb = 9'(req_ff.y_start) + 9'(req_ff.radius);
      if (cxb > 9'(FB_WIDTH - 1))  cxb = 9'(FB_WIDTH - 1);
      if (cyb > 9'(FB_HEIGHT - 1)) cyb = 9'(FB_HEIGHT - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == S_DONE);
         unique case (state_ff)
            S_INIT: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == (AW+1)'(BYTES - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (start) begin
                  req_ff <= req_item;
                  seg_ff <= '0;
                  rsp_byte_ff  <= '0;
                  rsp_valid_ff <= (req_item.mode == MODE_READ);
                  cnt_ff <= '0;
                  unique case (req_item.mode)
                     MODE_CLEAR_ALL: state_ff <= S_INIT;
                     MODE_READ: state_ff <= S_RRD;
                     MODE_SET_PX, MODE_CLR_PX, MODE_CHAR, MODE_RING, MODE_DISC,
                     MODE_HLINE, MODE_VLINE, MODE_RECT, MODE_FILL,
                     MODE_CLR_RECT: state_ff <= S_SEG;
                     default: state_ff <= S_DONE;
                  endcase
               end
            end
            S_SEG: begin
               r2_ff <= prod;
               priority if (req_ff.mode == MODE_SET_PX || req_ff.mode == MODE_CLR_PX
                            || (is_circ && req_ff.radius == 8'd0)) begin
                  xa_ff <= 9'(req_ff.x_start); xb_ff <= 9'(req_ff.x_start);
                  ya_ff <= 9'(req_ff.y_start); yb_ff <= 9'(req_ff.y_start);
                  x_ff  <= 9'(req_ff.x_start); y_ff  <= 9'(req_ff.y_start);
               end else if (req_ff.mode == MODE_CHAR) begin
                  xa_ff <= 9'(req_ff.x_start); xb_ff <= 9'(req_ff.x_start) + 9'(GLYPH_W - 1);
                  ya_ff <= 9'(req_ff.y_start); yb_ff <= 9'(req_ff.y_start) + 9'(GLYPH_H - 1);
                  x_ff  <= 9'(req_ff.x_start); y_ff  <= 9'(req_ff.y_start);
               end else if (is_circ) begin
                  xa_ff <= cxa; xb_ff <= cxb; ya_ff <= cya; yb_ff <= cyb;
                  x_ff <= cxa; y_ff <= cya;
               end else begin
                  xa_ff <= bx0; xb_ff <= bx1; ya_ff <= by0; yb_ff <= by1;
                  x_ff <= bx0; y_ff <= by0;
               end
               state_ff <= S_PIX;
            end
            S_PIX: begin
               // empty boxes (clipped away) skip straight on
               if (xa_ff > xb_ff || ya_ff > yb_ff) begin
                  if (last_seg) state_ff <= S_DONE;
                  else begin seg_ff <= seg_ff + 1'b1; state_ff <= S_SEG; end
               end else if (is_circ && req_ff.radius != 8'd0) begin
                  state_ff <= S_MUL1;
               end else begin
                  hit_ff <= inb;
                  state_ff <= S_RD;
               end
            end
            S_MUL1: begin
               d2_ff <= prod;
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               if (req_ff.mode == MODE_DISC) hit_ff <= inb && (d2_ff + prod <= r2_ff);
               else hit_ff <= inb && (d2_ff + prod >= rlo) && (d2_ff + prod <= rhi);
               state_ff <= S_RD;
            end
            S_RD: state_ff <= S_WAIT;
            S_WAIT: state_ff <= S_WR;
            S_WR: begin
               x_ff <= nx; y_ff <= ny;
               if (walk_end) begin
                  if (last_seg) state_ff <= S_DONE;
                  else begin seg_ff <= seg_ff + 1'b1; state_ff <= S_SEG; end
               end else begin
                  state_ff <= S_PIX;
               end
            end
            S_RRD: state_ff <= S_RWAIT;
            S_RWAIT: begin
               if ({1'b0, req_ff.x_start} < 9'(FB_WIDTH) && 9'(req_ff.y_start) < 9'(PAGES))
                  rsp_byte_ff <= ram_rd;
               state_ff <= S_DONE;
            end
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // clear-all re-enters the sweep; it must answer after it
   logic clr_pending_ff;
   always_ff @(posedge clock) begin
      if (reset) clr_pending_ff <= 1'b0;
      else if (state_ff == S_IDLE && start && req_item.mode == MODE_CLEAR_ALL)
         clr_pending_ff <= 1'b1;
      else if (state_ff == S_INIT && cnt_ff == (AW+1)'(BYTES - 1))
         clr_pending_ff <= 1'b0;
   end

   logic clr_done_ff;
   always_ff @(posedge clock) begin
      if (reset) clr_done_ff <= 1'b0;
      else clr_done_ff <= clr_pending_ff && state_ff == S_INIT
                          && cnt_ff == (AW+1)'(BYTES - 1);
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_done = done_ff || clr_done_ff;
   assign rsp_item.read_byte  = clr_done_ff ? 8'd0 : rsp_byte_ff;
   assign rsp_item.read_valid = clr_done_ff ? 1'b0 : rsp_valid_ff;

`ifndef SYNTHESIS
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_done |-> state_ff == S_IDLE) else $error("result outside idle");
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !ram_we) else $error("write while idle");
   a_read_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_item.read_valid && rsp_done |-> $past(state_ff, 2) == S_RWAIT)
      else $error("read flag without read");
`endif
endmodule
